// ===== hdl/srst_pkg.sv =====
// Shared types, widths and codes for the selective-repeat sender tracker.
// No dependencies; srst_seq, srst_out and the top level import this package.
`default_nettype none

package srst_pkg;

  localparam int MaxChunks = 32;
  localparam int TimeW     = 16;
  localparam int AddrW     = $clog2(MaxChunks);
  localparam int CountW    = 6;
  localparam int TotalW    = 6;
  localparam int IdxW      = 5;
  localparam int AckW      = 8;
  localparam int FuncW     = 2;
  localparam int KindW     = 3;
  localparam int EntryW    = TimeW + 1;

  localparam logic [FuncW-1:0] FuncStart = 2'd0;
  localparam logic [FuncW-1:0] FuncAck   = 2'd1;
  localparam logic [FuncW-1:0] FuncTick  = 2'd2;

  localparam logic [KindW-1:0] KindSend     = 3'd0;
  localparam logic [KindW-1:0] KindResend   = 3'd1;
  localparam logic [KindW-1:0] KindAckTaken = 3'd2;
  localparam logic [KindW-1:0] KindAckRange = 3'd3;
  localparam logic [KindW-1:0] KindComplete = 3'd4;

  typedef struct packed {
    logic [KindW-1:0]  kind;
    logic [IdxW-1:0]   idx;
    logic [CountW-1:0] count;
    logic              done;
  } res_t;

  typedef struct packed {
    logic valid;
    logic flush;
    res_t res;
  } cand_t;

endpackage

`default_nettype wire

// ===== hdl/srst_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
`default_nettype none

module srst_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== hdl/srst_seq.sv =====
// Request sequencer: message state, timeout register and the per-chunk entry
// RAM (acknowledged mark and send stamp). Depends on srst_pkg and srst_ram.
`default_nettype none

module srst_seq
  import srst_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [TimeW-1:0]   cfg_wdata_i,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [FuncW-1:0]   func_i,
  input  wire logic [TotalW-1:0]  chunk_total_i,
  input  wire logic [AckW-1:0]    ack_index_i,
  input  wire logic               stall_i,
  output cand_t                   cand_o
);

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StStart = 3'd1;
  localparam logic [2:0] StTick  = 3'd2;
  localparam logic [2:0] StAckEv = 3'd3;
  localparam logic [2:0] StBad   = 3'd4;
  localparam logic [2:0] StComp  = 3'd5;
  localparam logic [2:0] StFlush = 3'd6;

  logic [2:0]        state_q, state_d;
  logic [CountW-1:0] idx_q, idx_d;
  logic              v1_q, v1_d;
  logic [AddrW-1:0]  idx1_q, idx1_d;
  logic [AckW-1:0]   ackq_q, ackq_d;
  logic [TimeW-1:0]  tick_q, tick_d;
  logic [CountW-1:0] tally_q, tally_d;
  logic [CountW-1:0] chunks_q, chunks_d;
  logic              open_q, open_d;
  logic [TimeW-1:0]  timeout_q;

  logic              ram_we, ram_re;
  logic [AddrW-1:0]  ram_waddr, ram_raddr;
  logic [EntryW-1:0] ram_wdata, ram_rdata;

  logic              rd_mark;
  logic [TimeW-1:0]  rd_stamp;
  logic [TimeW-1:0]  age;
  logic [CountW-1:0] total_sat;
  logic [CountW-1:0] idx_nxt;
  logic [CountW-1:0] tally_new;

  srst_ram #(
    .Width (EntryW),
    .Depth (MaxChunks)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign in_ready_o = (state_q == StIdle);
  assign rd_mark    = ram_rdata[TimeW];
  assign rd_stamp   = ram_rdata[TimeW-1:0];
  assign age        = tick_q - rd_stamp;
  assign idx_nxt    = idx_q + CountW'(1);
  assign tally_new  = rd_mark ? tally_q : tally_q + CountW'(1);
  assign total_sat  = (CountW'(chunk_total_i) > CountW'(MaxChunks)) ?
                      CountW'(MaxChunks) : CountW'(chunk_total_i);

  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    v1_d      = v1_q;
    idx1_d    = idx1_q;
    ackq_d    = ackq_q;
    tick_d    = tick_q;
    tally_d   = tally_q;
    chunks_d  = chunks_q;
    open_d    = open_q;
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = '0;
    cand_o    = '0;

    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          case (func_i)
            FuncStart: begin
              tally_d  = '0;
              chunks_d = total_sat;
              idx_d    = '0;
              if (total_sat == '0) begin
                open_d  = 1'b0;
                state_d = StComp;
              end else begin
                open_d  = 1'b1;
                state_d = StStart;
              end
            end
            FuncAck: begin
              ackq_d = ack_index_i;
              if (open_q && (ack_index_i < AckW'(chunks_q))) begin
                ram_re    = 1'b1;
                ram_raddr = ack_index_i[AddrW-1:0];
                state_d   = StAckEv;
              end else begin
                state_d = StBad;
              end
            end
            FuncTick: begin
              tick_d = tick_q + TimeW'(1);
              idx_d  = '0;
              v1_d   = 1'b0;
              state_d = open_q ? StTick : StFlush;
            end
            default: begin
              state_d = StIdle;
            end
          endcase
        end
      end

      StStart: begin
        if (!stall_i) begin
          ram_we             = 1'b1;
          ram_waddr          = idx_q[AddrW-1:0];
          ram_wdata          = {1'b0, tick_q};
          cand_o.valid       = 1'b1;
          cand_o.res.kind    = KindSend;
          cand_o.res.idx     = idx_q[IdxW-1:0];
          cand_o.res.count   = tally_q;
          idx_d              = idx_nxt;
          if (idx_nxt == chunks_q) begin
            state_d = StFlush;
          end
        end
      end

      StTick: begin
        if (!stall_i) begin
          if (!v1_q && (idx_q >= chunks_q)) begin
            state_d = StFlush;
          end else begin
            if (idx_q < chunks_q) begin
              ram_re    = 1'b1;
              ram_raddr = idx_q[AddrW-1:0];
              idx_d     = idx_nxt;
              v1_d      = 1'b1;
              idx1_d    = idx_q[AddrW-1:0];
            end else begin
              v1_d = 1'b0;
            end
            if (v1_q && !rd_mark && (age >= timeout_q)) begin
              ram_we           = 1'b1;
              ram_waddr        = idx1_q;
              ram_wdata        = {1'b0, tick_q};
              cand_o.valid     = 1'b1;
              cand_o.res.kind  = KindResend;
              cand_o.res.idx   = IdxW'(idx1_q);
              cand_o.res.count = tally_q;
            end
          end
        end
      end

      StAckEv: begin
        if (!stall_i) begin
          ram_we           = !rd_mark;
          ram_waddr        = ackq_q[AddrW-1:0];
          ram_wdata        = {1'b1, rd_stamp};
          tally_d          = tally_new;
          cand_o.valid     = 1'b1;
          cand_o.res.kind  = KindAckTaken;
          cand_o.res.idx   = ackq_q[IdxW-1:0];
          cand_o.res.count = tally_new;
          if (tally_new == chunks_q) begin
            open_d  = 1'b0;
            state_d = StComp;
          end else begin
            state_d = StFlush;
          end
        end
      end

      StBad: begin
        if (!stall_i) begin
          cand_o.valid     = 1'b1;
          cand_o.res.kind  = KindAckRange;
          cand_o.res.idx   = ackq_q[IdxW-1:0];
          cand_o.res.count = tally_q;
          state_d          = StFlush;
        end
      end

      StComp: begin
        if (!stall_i) begin
          cand_o.valid     = 1'b1;
          cand_o.res.kind  = KindComplete;
          cand_o.res.count = tally_q;
          cand_o.res.done  = 1'b1;
          state_d          = StFlush;
        end
      end

      StFlush: begin
        if (!stall_i) begin
          cand_o.flush = 1'b1;
          state_d      = StIdle;
        end
      end

      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      idx_q     <= '0;
      v1_q      <= 1'b0;
      tick_q    <= '0;
      tally_q   <= '0;
      chunks_q  <= '0;
      open_q    <= 1'b0;
      timeout_q <= TimeW'(100);
    end else begin
      state_q  <= state_d;
      idx_q    <= idx_d;
      v1_q     <= v1_d;
      tick_q   <= tick_d;
      tally_q  <= tally_d;
      chunks_q <= chunks_d;
      open_q   <= open_d;
      if (cfg_we_i) begin
        timeout_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx1_q <= idx1_d;
    ackq_q <= ackq_d;
  end

endmodule

`default_nettype wire

// ===== hdl/srst_out.sv =====
// Result stage: holds one result back so the final one of a request can be
// marked last, then drives the output register. Depends on srst_pkg.
`default_nettype none

module srst_out
  import srst_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire cand_t              cand_i,
  output logic                    stall_o,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [KindW-1:0]        kind_o,
  output logic [IdxW-1:0]         chunk_index_o,
  output logic [CountW-1:0]       acked_count_o,
  output logic                    all_done_o,
  output logic                    last_o
);

  logic hold_v_q, hold_v_d;
  res_t hold_q, hold_d;
  logic out_v_q, out_v_d;
  res_t out_q, out_d;
  logic last_q, last_d;
  logic load;

  assign stall_o = out_v_q && !out_ready_i;

  always_comb begin
    hold_v_d = hold_v_q;
    hold_d   = hold_q;
    out_d    = out_q;
    last_d   = last_q;
    load     = 1'b0;
    if (!stall_o) begin
      if (cand_i.valid) begin
        if (hold_v_q) begin
          load   = 1'b1;
          out_d  = hold_q;
          last_d = 1'b0;
        end
        hold_d   = cand_i.res;
        hold_v_d = 1'b1;
      end else if (cand_i.flush) begin
        if (hold_v_q) begin
          load   = 1'b1;
          out_d  = hold_q;
          last_d = 1'b1;
        end
        hold_v_d = 1'b0;
      end
    end
    out_v_d = load || (out_v_q && !out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      hold_v_q <= hold_v_d;
      out_v_q  <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hold_q <= hold_d;
    out_q  <= out_d;
    last_q <= last_d;
  end

  assign out_valid_o   = out_v_q;
  assign kind_o        = out_q.kind;
  assign chunk_index_o = out_q.idx;
  assign acked_count_o = out_q.count;
  assign all_done_o    = out_q.done;
  assign last_o        = last_q;

endmodule

`default_nettype wire

// ===== hdl/selective_repeat_sender_tracker.sv =====
// Top level of the selective-repeat sender tracker.
// Depends on srst_pkg, srst_seq (with srst_ram) and srst_out.
//
//   channel | handshake              | payload
//   --------+------------------------+--------------------------------------------
//   cfg     | cfg_we_i               | cfg_wdata_i (retransmit timeout)
//   in      | in_valid_i / in_ready_o| func_i, chunk_total_i, ack_index_i
//   out     | out_valid_o/out_ready_i| kind_o, chunk_index_o, acked_count_o,
//           |                        | all_done_o, last_o
//
// One request at a time. Start of N chunks: one entry write per chunk;
// an empty start writes none.
// Tick: with a message open, a one-read-per-cycle scan of the entry RAM while
// the output does not stall; without one, no scan.
// Acknowledgement: read, modify, write back; func 3 is ignored.
// Reset needs no clearing pass: every entry is written on start before use.
// A stalled output freezes the scan; one result is held back to mark last.
`default_nettype none

module selective_repeat_sender_tracker
  import srst_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [TimeW-1:0]   cfg_wdata_i,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [FuncW-1:0]   func_i,
  input  wire logic [TotalW-1:0]  chunk_total_i,
  input  wire logic [AckW-1:0]    ack_index_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [KindW-1:0]        kind_o,
  output logic [IdxW-1:0]         chunk_index_o,
  output logic [CountW-1:0]       acked_count_o,
  output logic                    all_done_o,
  output logic                    last_o
);

  cand_t cand;
  logic  stall;

  srst_seq u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .func_i        (func_i),
    .chunk_total_i (chunk_total_i),
    .ack_index_i   (ack_index_i),
    .stall_i       (stall),
    .cand_o        (cand)
  );

  srst_out u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cand_i        (cand),
    .stall_o       (stall),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .kind_o        (kind_o),
    .chunk_index_o (chunk_index_o),
    .acked_count_o (acked_count_o),
    .all_done_o    (all_done_o),
    .last_o        (last_o)
  );

endmodule

`default_nettype wire
